// File: hdl/tcpq_pkg.sv
package tcpq_pkg;

    // Fixed field widths.
    localparam int KEY_W    = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Default store depth and threshold after reset.
    localparam int          DEPTH_DEFAULT = 16;
    localparam logic [KEY_W-1:0] THRESH_RESET = 8'd60;

    // Operation codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // How an insert wave behaves as it travels down the cell row.
    typedef enum logic [1:0] {
        MODE_SEEK,    // low-class key walking to the tail
        MODE_SEARCH,  // high-class key looking for the first smaller entry
        MODE_SHIFT    // displaced entry moving one place down
    } t_mode;

    // Insert wave handed from one cell to the next.
    typedef struct packed {
        logic             valid;
        t_mode            mode;
        logic [KEY_W-1:0] value;
    } t_wave;

endpackage

// File: hdl/tcpq_if.sv
// Request channel: one operation per beat.
interface tcpq_req_if
    import tcpq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [KEY_W-1:0] key_value;

    modport source (output valid, output operation, output key_value, input ready);
    modport sink   (input valid, input operation, input key_value, output ready);
endinterface

// Response channel: one result per beat.
interface tcpq_rsp_if
    import tcpq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KEY_W-1:0]    head_value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output head_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input head_value, input status, input occupancy,
                    output ready);
endinterface

// File: hdl/two_class_priority_queue.sv
// Two-class priority queue of 8-bit keys.
// Requests arrive on i_req: operation 0 inserts key_value, 1 pops the head.
// Each request gives exactly one response beat on o_rsp with the popped key
// (zero otherwise), a status (done, insert dropped on full, pop on empty) and
// the occupancy after the operation.
// A key at or above the threshold register goes in front of the first stored
// key that is strictly smaller; a smaller key joins the tail. The user must
// write the threshold through i_cfg_we / i_cfg_wdata only while the queue is
// idle; the block itself does not enforce this. Entries live in a row of DEPTH
// cells. A pop shifts the whole row up at once, and its response appears in
// the cycle after the request beat. An insert sends a wave down the row, one
// cell per cycle, until it reaches the first free cell; the response then
// appears, and the next request is taken once it is out. Full-insert and
// empty-pop responses appear in the cycle after the request beat.
// A synchronous low reset empties the queue and sets the threshold to 60.
// The response waits in an output register while o_rsp.ready is low; no new
// request is taken until that register can be refilled.
module two_class_priority_queue
    import tcpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcpq_req_if.sink         i_req,
    tcpq_rsp_if.source       o_rsp,
    input  logic             i_cfg_we,
    input  logic [KEY_W-1:0] i_cfg_wdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_INSERT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [KEY_W-1:0]    r_thresh;
    t_wave               r_start;
    logic                r_out_valid;
    logic [KEY_W-1:0]    r_out_head;
    logic [STATUS_W-1:0] r_out_status;
    logic [OCC_W-1:0]    r_out_occ;

    logic                w_accept;
    logic                w_shift_up;
    logic                w_full;
    logic                w_empty;
    logic                w_done;
    logic [DEPTH-1:0]    w_done_vec;
    t_wave               w_wave  [0:DEPTH];
    logic [KEY_W-1:0]    w_entry [0:DEPTH];

    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_done   = |w_done_vec;

    // One request at a time; the output register must be free for its result.
    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_shift_up  = w_accept && (i_req.operation == OP_REMOVE) && !w_empty;

    // Cell row: the wave enters at the head, entries shift toward the head.
    assign w_wave[0]      = r_start;
    assign w_entry[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        tcpq_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_shift_up   (w_shift_up),
            .i_count      (r_count),
            .i_next_entry (w_entry[g+1]),
            .i_wave       (w_wave[g]),
            .o_wave       (w_wave[g+1]),
            .o_entry      (w_entry[g]),
            .o_done       (w_done_vec[g])
        );
    end

    // Sequencer, count, threshold and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_thresh      <= THRESH_RESET;
            r_start.valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_start.valid <= 1'b0;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_req.operation == OP_INSERT) begin
                            if (w_full) begin
                                r_out_valid  <= 1'b1;
                                r_out_head   <= '0;
                                r_out_status <= STATUS_FULL;
                                r_out_occ    <= OCC_W'(r_count);
                            end else begin
                                r_start.valid <= 1'b1;
                                r_start.mode  <= (i_req.key_value >= r_thresh) ?
                                                 MODE_SEARCH : MODE_SEEK;
                                r_start.value <= i_req.key_value;
                                r_state       <= ST_INSERT;
                            end
                        end else begin
                            r_out_valid <= 1'b1;
                            if (w_empty) begin
                                r_out_head   <= '0;
                                r_out_status <= STATUS_EMPTY;
                                r_out_occ    <= OCC_W'(r_count);
                            end else begin
                                r_out_head   <= w_entry[0];
                                r_out_status <= STATUS_DONE;
                                r_out_occ    <= OCC_W'(r_count - 1'b1);
                                r_count      <= r_count - 1'b1;
                            end
                        end
                    end
                end
                ST_INSERT: begin
                    if (w_done) begin
                        r_count      <= r_count + 1'b1;
                        r_out_valid  <= 1'b1;
                        r_out_head   <= '0;
                        r_out_status <= STATUS_DONE;
                        r_out_occ    <= OCC_W'(r_count + 1'b1);
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.head_value = r_out_head;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.occupancy  = r_out_occ;

    // The wave always lands at the tail, so it never leaves the row.
    a_wave_stays_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_wave[DEPTH].valid)
        else $error("insert wave ran past the last cell");

    // At most one cell takes the key at the end of an insert.
    a_single_landing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_done_vec))
        else $error("more than one cell finished the insert wave");

    // A wave only travels while an insert is in progress.
    a_done_in_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == ST_INSERT))
        else $error("insert wave finished outside an insert");

    // The count never exceeds the row length.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // A finished insert adds exactly one entry.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INSERT && w_done) |=>
            (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("insert did not add one entry");

endmodule

// File: hdl/tcpq_cell.sv
// One storage cell of the queue row. Holds one entry and one stage of the
// insert wave, which moves one cell further on every cycle.
module tcpq_cell
    import tcpq_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift_up,
    input  logic [CNT_W-1:0] i_count,
    input  logic [KEY_W-1:0] i_next_entry,
    input  t_wave            i_wave,
    output t_wave            o_wave,
    output logic [KEY_W-1:0] o_entry,
    output logic             o_done
);

    logic [KEY_W-1:0] r_entry;
    logic [KEY_W-1:0] n_entry;
    t_wave            r_wave;
    t_wave            n_wave;
    logic             w_is_tail;

    // This cell is the first free place of the row.
    assign w_is_tail = (i_count == CNT_W'(INDEX));

    // Pop, tail write, or one step of the insert wave.
    always_comb begin
        n_entry       = r_entry;
        n_wave        = i_wave;
        n_wave.valid  = 1'b0;
        o_done        = 1'b0;
        if (i_shift_up) begin
            n_entry = i_next_entry;
        end else if (i_wave.valid) begin
            if (w_is_tail) begin
                // The wave ends here: whatever it carries takes the free place.
                n_entry = i_wave.value;
                o_done  = 1'b1;
            end else begin
                n_wave.valid = 1'b1;
                case (i_wave.mode)
                    MODE_SEEK: begin
                        n_wave.mode = MODE_SEEK;
                    end
                    MODE_SEARCH: begin
                        if (r_entry < i_wave.value) begin
                            n_entry      = i_wave.value;
                            n_wave.mode  = MODE_SHIFT;
                            n_wave.value = r_entry;
                        end
                    end
                    MODE_SHIFT: begin
                        n_entry      = i_wave.value;
                        n_wave.value = r_entry;
                    end
                    default: begin
                        n_wave.valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // The entry itself needs no reset; the wave stage does.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_wave.valid <= 1'b0;
        end else begin
            r_wave <= n_wave;
        end
    end

    assign o_wave  = r_wave;
    assign o_entry = r_entry;

endmodule
